// ----- rtl/pe_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pe_pkg: shared types and constants for the particle Euler step block
// Item and result layouts, FSM states, trail cell opcodes, register map.
// ---------------------------------------------------------------------------
package pe_pkg;

  // Field widths (fixed by the item formats)
  localparam int POS_W     = 24;  // signed Q11.12
  localparam int DT_W      = 16;  // unsigned Q4.12
  localparam int COLOR_W   = 8;
  localparam int LIFE_W    = 4;
  localparam int ELAPSED_W = 20;  // unsigned Q8.12
  localparam int GRAV_W    = 23;
  localparam int AREA_W    = 11;
  localparam int FRAC_W    = 12;

  // Shared divider operand width: fade numerator is 12 bits after the shift
  localparam int DIV_DVD_W = 12;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_GRAVITY = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_HEIGHT  = 2'd2
  } reg_index_t;

  localparam logic [GRAV_W-1:0]    GRAVITY_RST = 23'd40960;
  localparam logic [AREA_W-1:0]    WIDTH_RST   = 11'd800;
  localparam logic [AREA_W-1:0]    HEIGHT_RST  = 11'd600;
  localparam logic [COLOR_W-1:0]   ALPHA_FULL  = 8'd255;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 20'hFFFFF;

  // Command codes
  localparam logic CMD_SPAWN = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STATUS,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_G,
    ST_ADD_G,
    ST_DIV_A,
    ST_DIV_F,
    ST_EMIT
  } fsm_state_t;

  // What a trail cell loads this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,   // keep contents
    CELL_SHIFT,  // take the neighbor's entry
    CELL_LOAD,   // take the newly appended position
    CELL_WRAP    // take the oldest entry (rotation wrap-around)
  } cell_op_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } trail_point_t;

  typedef struct packed {
    logic                    cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      blue;
    logic [LIFE_W-1:0]       life_seconds;
    logic [DT_W-1:0]         delta_time;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] trail_x;
    logic signed [POS_W-1:0] trail_y;
    logic [COLOR_W-1:0]      trail_alpha;
    logic                    trail_valid;
    logic signed [POS_W-1:0] head_x;
    logic signed [POS_W-1:0] head_y;
    logic [COLOR_W-1:0]      head_alpha;
    logic [COLOR_W-1:0]      color_green;
    logic [COLOR_W-1:0]      color_blue;
    logic                    alive;
    logic                    last;
  } out_item_t;

endpackage

// ----- rtl/pe_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pe_if: valid/ready stream interfaces for items and results
// One transfer when valid and ready are both high at a rising clock edge.
// ---------------------------------------------------------------------------
interface pe_item_if;
  import pe_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pe_result_if;
  import pe_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pe_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pe_div: restoring unsigned divider, one quotient bit per cycle
// Operands latched on start; done pulses as the last step is registered.
// ---------------------------------------------------------------------------
module pe_div #(
  parameter int DVD_W = 12,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] step_cnt;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             fits;

  // One restoring step
  assign trial     = {rem, quo[DVD_W-1]};
  assign fits      = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      step_cnt <= CNT_W'(DVD_W);
    end else if (busy) begin
      step_cnt <= step_cnt - CNT_W'(1);
      if (step_cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Quotient and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], fits};
      rem <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- rtl/pe_trail_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pe_trail_cell: one trail position in the cell chain
// Holds, shifts from its neighbor, loads a new position or wraps the oldest.
// ---------------------------------------------------------------------------
module pe_trail_cell (
  input  logic                  clk,
  input  pe_pkg::cell_op_t      op,
  input  pe_pkg::trail_point_t  next_pt,
  input  pe_pkg::trail_point_t  new_pt,
  input  pe_pkg::trail_point_t  first_pt,
  output pe_pkg::trail_point_t  pt
);
  import pe_pkg::*;

  trail_point_t pt_next;

  // Source select
  always_comb begin
    case (op)
      CELL_SHIFT: pt_next = next_pt;
      CELL_LOAD:  pt_next = new_pt;
      CELL_WRAP:  pt_next = first_pt;
      default:    pt_next = pt;
    endcase
  end

  always_ff @(posedge clk) begin
    pt <= pt_next;
  end

endmodule

// ----- rtl/particle_euler_step_with_trail.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_euler_step_with_trail: one particle, Euler step, fading trail
// Fixed-point particle integrator with a chain of trail cells.
//
//   port     | dir  | kind          | transfer
//   ---------+------+---------------+-----------------------------------
//   items    | sink | valid/ready   | spawn or tick command
//   results  | src  | valid/ready   | status or one trail entry
//   apb      | in   | APB write/rd  | psel & penable & pwrite & pready
//
// Spawn or ignored tick: one status result from ST_STATUS, then back to ST_IDLE
// for the next item.
// Updating tick, for n trail entries: ST_MUL_X, ST_MUL_Y, ST_MUL_G and ST_ADD_G
// on the shared multiplier and adder, two runs of the 12-step serial divider,
// n entries rotated out of the cell chain one per cycle while the results port
// accepts, then a return to ST_IDLE.
// Reset: synchronous; no clearing pass, trail cells are only read once filled.
// A stalled results port holds the output register and pauses the rotation.
// ---------------------------------------------------------------------------
module particle_euler_step_with_trail #(
  parameter int TRAIL_DEPTH = 21
) (
  input  logic                        clk,
  input  logic                        rst,
  pe_item_if.sink                     items,
  pe_result_if.source                 results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pe_pkg::ADDR_W-1:0]   paddr,
  input  logic [pe_pkg::DATA_W-1:0]   pwdata,
  output logic [pe_pkg::DATA_W-1:0]   prdata,
  output logic                        pready
);
  import pe_pkg::*;

  localparam int CNT_W = $clog2(TRAIL_DEPTH + 1);
  localparam int DVS_W = (CNT_W > LIFE_W) ? CNT_W : LIFE_W;

  // Configuration registers
  logic [GRAV_W-1:0] gravity_y;
  logic [AREA_W-1:0] area_width;
  logic [AREA_W-1:0] area_height;

  // Particle state
  logic signed [POS_W-1:0] position_x;
  logic signed [POS_W-1:0] position_y;
  logic signed [POS_W-1:0] velocity_x;
  logic signed [POS_W-1:0] velocity_y;
  logic [COLOR_W-1:0]      shade_green;
  logic [COLOR_W-1:0]      shade_blue;
  logic [COLOR_W-1:0]      fade_alpha;
  logic [LIFE_W-1:0]       life_total;
  logic [ELAPSED_W-1:0]    elapsed_time;
  logic [CNT_W-1:0]        trail_count;

  // Working registers for one tick
  logic [DT_W-1:0]         dt_reg;
  logic [COLOR_W-1:0]      prev_alpha;
  logic signed [40:0]      prod;
  logic [COLOR_W-1:0]      q_step;
  logic [CNT_W-1:0]        r_step;
  logic [COLOR_W-1:0]      q_acc;
  logic [CNT_W-1:0]        r_acc;
  logic [CNT_W-1:0]        emit_idx;

  // Output register
  logic      out_valid;
  out_item_t out_data;

  fsm_state_t state;
  fsm_state_t state_next;

  // FSM outputs
  logic in_rdy;
  logic div_start;
  logic div_sel_fade;
  logic out_free;
  logic out_load_en;
  logic rotate;

  // ---------------- configuration port ----------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_y   <= GRAVITY_RST;
      area_width  <= WIDTH_RST;
      area_height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GRAVITY: gravity_y   <= pwdata[GRAV_W-1:0];
        REG_WIDTH:   area_width  <= pwdata[AREA_W-1:0];
        REG_HEIGHT:  area_height <= pwdata[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRAVITY: prdata = DATA_W'(gravity_y);
      REG_WIDTH:   prdata = DATA_W'(area_width);
      REG_HEIGHT:  prdata = DATA_W'(area_height);
      default:     prdata = '0;
    endcase
  end

  // ---------------- alive test ----------------
  logic [15:0] span16;
  logic        alive_now;
  assign span16    = {life_total, {FRAC_W{1'b0}}};
  assign alive_now = (elapsed_time <= ELAPSED_W'(span16)) &&
                     !position_x[POS_W-1] && !position_y[POS_W-1] &&
                     (position_x[POS_W-2:0] <= {area_width, {FRAC_W{1'b0}}}) &&
                     (position_y[POS_W-2:0] <= {area_height, {FRAC_W{1'b0}}});

  // ---------------- input decode ----------------
  logic in_xfer;
  logic is_spawn;
  logic upd_tick;
  logic trail_full;
  assign in_xfer    = items.valid & in_rdy;
  assign is_spawn   = items.data.cmd == CMD_SPAWN;
  assign upd_tick   = in_xfer && !is_spawn && (items.data.delta_time != '0) && alive_now;
  assign trail_full = trail_count == CNT_W'(TRAIL_DEPTH);

  // ---------------- emission bookkeeping ----------------
  logic           emit_last;
  logic [CNT_W:0] r_sum;
  logic           r_wrap;
  assign emit_last = (emit_idx + CNT_W'(1)) == trail_count;
  assign r_sum     = {1'b0, r_acc} + {1'b0, r_step};
  assign r_wrap    = r_sum >= {1'b0, trail_count};

  // ---------------- shared divider ----------------
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0]     div_divisor;
  logic                 div_done;
  logic [DIV_DVD_W-1:0] div_quo;
  logic [DVS_W-1:0]     div_rem;

  // Fade numerator: floor((span - elapsed) * 255 / 4096)
  logic [15:0] fade_diff;
  logic [23:0] fade_scaled;
  logic        fade_ok;
  assign fade_ok     = elapsed_time < ELAPSED_W'(span16);
  assign fade_diff   = span16 - elapsed_time[15:0];
  assign fade_scaled = {fade_diff, 8'b0} - {8'b0, fade_diff};

  assign div_dividend = div_sel_fade ? fade_scaled[23:FRAC_W] : DIV_DVD_W'(prev_alpha);
  assign div_divisor  = div_sel_fade ? DVS_W'(life_total) : DVS_W'(trail_count);

  pe_div #(
    .DVD_W (DIV_DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // ---------------- shared multiplier ----------------
  logic signed [POS_W-1:0] mul_a;
  logic signed [DT_W:0]    mul_b;
  logic signed [40:0]      mul_full;
  always_comb begin
    case (state)
      ST_MUL_X: mul_a = velocity_x;
      ST_MUL_Y: mul_a = velocity_y;
      default:  mul_a = $signed({1'b0, gravity_y});
    endcase
  end
  assign mul_b    = $signed({1'b0, dt_reg});
  assign mul_full = 41'(mul_a) * 41'(mul_b);

  // Add the floored product (>>> 12) to a state value, saturating
  function automatic logic signed [POS_W-1:0] add_sat(
    input logic signed [POS_W-1:0] base,
    input logic signed [40:0]      p
  );
    logic signed [29:0] sum;
    sum = $signed({{6{base[POS_W-1]}}, base}) + $signed({p[40], p[40:FRAC_W]});
    if (sum > 30'sd8388607) begin
      add_sat = 24'sh7FFFFF;
    end else if (sum < -30'sd8388608) begin
      add_sat = 24'sh800000;
    end else begin
      add_sat = sum[POS_W-1:0];
    end
  endfunction

  logic [ELAPSED_W:0] elapsed_sum;
  assign elapsed_sum = {1'b0, elapsed_time} + (ELAPSED_W + 1)'(dt_reg);

  // ---------------- trail cell chain ----------------
  trail_point_t cell_pt [TRAIL_DEPTH];
  cell_op_t     cell_op [TRAIL_DEPTH];
  trail_point_t new_pt;
  assign new_pt = '{x: position_x, y: position_y};

  for (genvar i = 0; i < TRAIL_DEPTH; i++) begin : g_cell
    trail_point_t nb_pt;
    if (i == TRAIL_DEPTH - 1) begin : g_end
      assign nb_pt = new_pt;
    end else begin : g_mid
      assign nb_pt = cell_pt[i+1];
    end

    always_comb begin
      if (upd_tick) begin
        if (trail_full) begin
          cell_op[i] = (i == TRAIL_DEPTH - 1) ? CELL_LOAD : CELL_SHIFT;
        end else begin
          cell_op[i] = (trail_count == CNT_W'(i)) ? CELL_LOAD : CELL_HOLD;
        end
      end else if (rotate) begin
        if (CNT_W'(i + 1) < trail_count) begin
          cell_op[i] = CELL_SHIFT;
        end else if (CNT_W'(i + 1) == trail_count) begin
          cell_op[i] = CELL_WRAP;
        end else begin
          cell_op[i] = CELL_HOLD;
        end
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end

    pe_trail_cell u_cell (
      .clk      (clk),
      .op       (cell_op[i]),
      .next_pt  (nb_pt),
      .new_pt   (new_pt),
      .first_pt (cell_pt[0]),
      .pt       (cell_pt[i])
    );
  end

  // ---------------- FSM ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (items.valid) begin
          state_next = upd_tick ? ST_MUL_X : ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_MUL_G;
      ST_MUL_G: state_next = ST_ADD_G;
      ST_ADD_G: state_next = ST_DIV_A;
      ST_DIV_A: begin
        if (div_done) state_next = ST_DIV_F;
      end
      ST_DIV_F: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  assign out_free = !out_valid || results.ready;
  always_comb begin
    in_rdy       = 1'b0;
    div_start    = 1'b0;
    div_sel_fade = 1'b0;
    out_load_en  = 1'b0;
    rotate       = 1'b0;
    case (state)
      ST_IDLE:   in_rdy = 1'b1;
      ST_STATUS: out_load_en = out_free;
      ST_ADD_G:  div_start = 1'b1;
      ST_DIV_A: begin
        div_sel_fade = 1'b1;
        div_start    = div_done;
      end
      ST_EMIT: begin
        out_load_en = out_free;
        rotate      = out_free;
      end
      default: ;
    endcase
  end

  assign items.ready = in_rdy;

  // ---------------- particle state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x   <= '0;
      position_y   <= '0;
      velocity_x   <= '0;
      velocity_y   <= '0;
      shade_green  <= '0;
      shade_blue   <= '0;
      fade_alpha   <= '0;
      life_total   <= LIFE_W'(1);
      elapsed_time <= '0;
      trail_count  <= '0;
      emit_idx     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer && is_spawn) begin
            position_x   <= items.data.pos_x;
            position_y   <= items.data.pos_y;
            velocity_x   <= items.data.vel_x;
            velocity_y   <= items.data.vel_y;
            shade_green  <= items.data.green;
            shade_blue   <= items.data.blue;
            life_total   <= items.data.life_seconds;
            fade_alpha   <= ALPHA_FULL;
            elapsed_time <= '0;
            trail_count  <= '0;
          end else if (upd_tick) begin
            trail_count <= trail_full ? trail_count : trail_count + CNT_W'(1);
          end
        end
        ST_MUL_Y: position_x <= add_sat(position_x, prod);
        ST_MUL_G: position_y <= add_sat(position_y, prod);
        ST_ADD_G: velocity_y <= add_sat(velocity_y, prod);
        ST_DIV_F: begin
          if (div_done) begin
            fade_alpha   <= fade_ok ? div_quo[COLOR_W-1:0] : '0;
            elapsed_time <= elapsed_sum[ELAPSED_W] ? ELAPSED_MAX
                                                   : elapsed_sum[ELAPSED_W-1:0];
            emit_idx     <= '0;
          end
        end
        ST_EMIT: begin
          if (rotate) emit_idx <= emit_idx + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // ---------------- tick datapath ----------------
  always_ff @(posedge clk) begin
    if (upd_tick) begin
      dt_reg     <= items.data.delta_time;
      prev_alpha <= fade_alpha;
    end
    prod <= mul_full;
    if (state == ST_DIV_A && div_done) begin
      q_step <= div_quo[COLOR_W-1:0];
      r_step <= div_rem[CNT_W-1:0];
    end
    if (state == ST_DIV_F && div_done) begin
      q_acc <= q_step;
      r_acc <= r_step;
    end else if (rotate) begin
      if (r_wrap) begin
        q_acc <= q_acc + q_step + COLOR_W'(1);
        r_acc <= CNT_W'(r_sum - {1'b0, trail_count});
      end else begin
        q_acc <= q_acc + q_step;
        r_acc <= r_sum[CNT_W-1:0];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load_en) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_en) begin
      out_data.head_x      <= position_x;
      out_data.head_y      <= position_y;
      out_data.head_alpha  <= fade_alpha;
      out_data.color_green <= shade_green;
      out_data.color_blue  <= shade_blue;
      out_data.alive       <= alive_now;
      if (state == ST_EMIT) begin
        out_data.trail_x     <= cell_pt[0].x;
        out_data.trail_y     <= cell_pt[0].y;
        out_data.trail_alpha <= q_acc;
        out_data.trail_valid <= 1'b1;
        out_data.last        <= emit_last;
      end else begin
        out_data.trail_x     <= '0;
        out_data.trail_y     <= '0;
        out_data.trail_alpha <= '0;
        out_data.trail_valid <= 1'b0;
        out_data.last        <= 1'b1;
      end
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

  // ---------------- assertions ----------------
  a_div_done_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_A || state == ST_DIV_F))
    else $error("divider finished outside a divide state");

  a_append_nonempty: assert property (@(posedge clk) disable iff (rst)
    upd_tick |=> (trail_count != '0) && (state == ST_MUL_X))
    else $error("updating tick left trail empty or skipped the step");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (rotate && emit_last) |=> (state == ST_IDLE) && out_data.last)
    else $error("final trail entry did not end the tick");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.data.trail_valid) |-> results.data.last)
    else $error("status result not flagged last");

endmodule
